// ----- src/order_book_price_level_table_unit_macros.svh -----
// assertion macros for the order book price level table
`ifndef ORDER_BOOK_PRICE_LEVEL_TABLE_UNIT_MACROS_SVH
`define ORDER_BOOK_PRICE_LEVEL_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define OBPLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("obplt check failed");
`define OBPLT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("obplt sequence check failed");
`else
`define OBPLT_ASSERT(lbl, prop)
`define OBPLT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- src/obplt_pkg.sv -----
package obplt_pkg;

  localparam int LEVELS     = 32;
  localparam int PRICE_W    = 32;
  localparam int QTY_W      = 32;
  localparam int FILL_W     = 32;
  localparam int SLOT_W     = 5;
  localparam int ACTION_W   = 3;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_NONE   = 3'd3,
    ACT_BEYOND = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE_IS_BID = 2'd0,
    CFG_EMPTY_MARK  = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEL,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_HOLD,
    PH_CMP,
    PH_SEL,
    PH_APPLY,
    PH_FILL
  } cell_phase_t;

  typedef struct packed {
    cell_phase_t         phase;
    logic                side_is_bid;
    action_t             op;
    logic [FILL_W-1:0]   fill;
    logic [PRICE_W-1:0]  req_price;
    logic [QTY_W-1:0]    req_qty;
  } cell_bus_t;

endpackage

// ----- src/obplt_in_if.sv -----
interface obplt_in_if;
  import obplt_pkg::*;

  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] level_price;
  logic [QTY_W-1:0]   level_quantity;

  modport source (output valid, output level_price, output level_quantity, input ready);
  modport sink   (input valid, input level_price, input level_quantity, output ready);
endinterface

// ----- src/obplt_out_if.sv -----
interface obplt_out_if;
  import obplt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SLOT_W-1:0]   slot;
  logic [PRICE_W-1:0]  best_price;
  logic [QTY_W-1:0]    best_quantity;
  logic [COUNT_W-1:0]  update_count;

  modport source (output valid, output action, output slot, output best_price,
                  output best_quantity, output update_count, input ready);
  modport sink   (input valid, input action, input slot, input best_price,
                  input best_quantity, input update_count, output ready);
endinterface

// ----- src/obplt_cfg_if.sv -----
interface obplt_cfg_if;
  import obplt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/obplt_cell.sv -----
module obplt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  obplt_pkg::cell_bus_t        bus,
  input  logic [obplt_pkg::PRICE_W-1:0] left_price,
  input  logic [obplt_pkg::QTY_W-1:0]   left_qty,
  input  logic [obplt_pkg::PRICE_W-1:0] right_price,
  input  logic [obplt_pkg::QTY_W-1:0]   right_qty,
  input  logic                        prior_in,
  output logic                        prior_out,
  output logic                        first_sel,
  output logic                        first_q,
  output logic                        same_q,
  output logic [obplt_pkg::PRICE_W-1:0] price_q,
  output logic [obplt_pkg::QTY_W-1:0]   qty_q
);
  import obplt_pkg::*;

  logic [PRICE_W-1:0] price_r, price_nxt;
  logic [QTY_W-1:0]   qty_r, qty_nxt;
  logic               ok_r, same_r, first_r, after_r;

  // a cell qualifies when it is not ahead of the request price
  assign prior_out = prior_in | ok_r;
  assign first_sel = ok_r & ~prior_in;

  always_comb begin
    price_nxt = price_r;
    qty_nxt   = qty_r;
    case (bus.phase)
      PH_FILL: begin
        price_nxt = PRICE_W'(bus.fill);
        qty_nxt   = QTY_W'(bus.fill);
      end
      PH_APPLY: begin
        if (first_r) begin
          case (bus.op)
            ACT_INSERT: begin
              price_nxt = bus.req_price;
              qty_nxt   = bus.req_qty;
            end
            ACT_DELETE: begin
              price_nxt = right_price;
              qty_nxt   = right_qty;
            end
            ACT_UPDATE: qty_nxt = bus.req_qty;
            default: ;
          endcase
        end else if (after_r) begin
          case (bus.op)
            ACT_INSERT: begin
              price_nxt = left_price;
              qty_nxt   = left_qty;
            end
            ACT_DELETE: begin
              price_nxt = right_price;
              qty_nxt   = right_qty;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      price_r <= '0;
      qty_r   <= '0;
      ok_r    <= 1'b0;
      same_r  <= 1'b0;
      first_r <= 1'b0;
      after_r <= 1'b0;
    end else begin
      price_r <= price_nxt;
      qty_r   <= qty_nxt;
      if (bus.phase == PH_CMP) begin
        ok_r   <= bus.side_is_bid ? (price_r <= bus.req_price)
                                  : (price_r >= bus.req_price);
        same_r <= (price_r == bus.req_price);
      end
      if (bus.phase == PH_SEL) begin
        first_r <= first_sel;
        after_r <= prior_in;
      end
    end
  end

  assign first_q = first_r;
  assign same_q  = same_r;
  assign price_q = price_r;
  assign qty_q   = qty_r;

endmodule

// ----- src/order_book_price_level_table_unit.sv -----
// one side of an order book kept as a sorted row of price level cells
// in_ch carries level updates (price in ticks, quantity in lots), one beat each;
// out_ch returns exactly one result beat per update: action, selected slot,
// best level after the update and the running change count
// cfg_ch writes side_is_bid (index 0) or the empty-slot mark (index 1); a mark
// write refills every cell at once and bumps the change count
// each update passes these steps from accept to result: compare in all cells,
// first-hit select rippling down the cell row, apply the shift or update,
// then load the output register; a new update is taken only once the last
// result is loaded, as the sequencer takes the next beat only while idle
// the output register lets the next update be accepted while a result waits;
// if out_ch stalls, the sequencer holds its result until the beat is taken
// reset: asks side, fill value 0 in every cell, change count 1, no result
`include "order_book_price_level_table_unit_macros.svh"

module order_book_price_level_table_unit (
  input  logic clk,
  input  logic rst_n,
  obplt_in_if.sink    in_ch,
  obplt_out_if.source out_ch,
  obplt_cfg_if.sink   cfg_ch
);
  import obplt_pkg::*;

  state_t state_r, state_nxt;

  // request and config registers
  logic [PRICE_W-1:0] req_price_r;
  logic [QTY_W-1:0]   req_qty_r;
  logic               side_r;
  logic [FILL_W-1:0]  fill_r;
  logic [COUNT_W-1:0] count_r;

  // decision taken in the select step
  action_t            op_r, op_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_sel;
  logic               found_r;

  // output register
  logic                out_valid_r;
  action_t             out_action_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [PRICE_W-1:0]  out_price_r;
  logic [QTY_W-1:0]    out_qty_r;
  logic [COUNT_W-1:0]  out_count_r;

  // cell row wiring
  cell_bus_t          bus;
  cell_phase_t        phase;
  logic [LEVELS:0]    prior;
  logic [LEVELS-1:0]  first_sel, first_q, same_q;
  logic [PRICE_W-1:0] cell_price [LEVELS];
  logic [QTY_W-1:0]   cell_qty   [LEVELS];
  logic               same_hit;

  logic in_fire, cfg_fire, fill_wr, emit_load;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;
  assign fill_wr      = cfg_fire & (cfg_ch.index == CFG_EMPTY_MARK);
  assign emit_load    = (state_r == ST_EMIT) & (~out_valid_r | out_ch.ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    phase     = PH_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        phase     = PH_CMP;
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        phase     = PH_SEL;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        phase     = PH_APPLY;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    // fill writes must arrive only while the sequencer is idle; the block does not enforce it
    if (fill_wr) phase = PH_FILL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign bus.phase       = phase;
  assign bus.side_is_bid = side_r;
  assign bus.op          = op_r;
  assign bus.fill        = fill_r;
  assign bus.req_price   = req_price_r;
  assign bus.req_qty     = req_qty_r;

  // refill data comes straight from the write beat
  cell_bus_t cell_bus;
  always_comb begin
    cell_bus = bus;
    if (fill_wr) cell_bus.fill = FILL_W'(cfg_ch.data);
  end

  // first-hit token ripples from slot 0 toward the tail
  assign prior[0] = 1'b0;

  for (genvar g = 0; g < LEVELS; g++) begin : g_cell
    logic [PRICE_W-1:0] lp, rp;
    logic [QTY_W-1:0]   lq, rq;
    if (g == 0) begin : g_head
      assign lp = cell_price[0];
      assign lq = cell_qty[0];
    end else begin : g_mid
      assign lp = cell_price[g-1];
      assign lq = cell_qty[g-1];
    end
    // the tail refills with the fill value on a delete
    if (g == LEVELS - 1) begin : g_tail
      assign rp = PRICE_W'(fill_r);
      assign rq = QTY_W'(fill_r);
    end else begin : g_body
      assign rp = cell_price[g+1];
      assign rq = cell_qty[g+1];
    end

    obplt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .bus         (cell_bus),
      .left_price  (lp),
      .left_qty    (lq),
      .right_price (rp),
      .right_qty   (rq),
      .prior_in    (prior[g]),
      .prior_out   (prior[g+1]),
      .first_sel   (first_sel[g]),
      .first_q     (first_q[g]),
      .same_q      (same_q[g]),
      .price_q     (cell_price[g]),
      .qty_q       (cell_qty[g])
    );
  end

  // slot encode and equal-price check over the one-hot first hit
  always_comb begin
    slot_sel = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (first_sel[i]) slot_sel = slot_sel | SLOT_W'(i);
    end
  end

  assign same_hit = |(first_sel & same_q);

  always_comb begin
    if (!prior[LEVELS]) begin
      op_nxt = ACT_BEYOND;
    end else if (!same_hit && (req_qty_r != '0)) begin
      op_nxt = ACT_INSERT;
    end else if (same_hit && (req_qty_r == '0)) begin
      op_nxt = ACT_DELETE;
    end else if (req_qty_r != '0) begin
      op_nxt = ACT_UPDATE;
    end else begin
      op_nxt = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r      <= 1'b0;
      fill_r      <= '0;
      count_r     <= COUNT_W'(1);
      out_valid_r <= 1'b0;
      op_r        <= ACT_NONE;
      found_r     <= 1'b0;
    end else begin
      if (cfg_fire && (cfg_ch.index == CFG_SIDE_IS_BID)) side_r <= cfg_ch.data[0];
      if (fill_wr) begin
        fill_r  <= FILL_W'(cfg_ch.data);
        count_r <= count_r + COUNT_W'(1);
      end
      if (state_r == ST_SEL) begin
        op_r    <= op_nxt;
        found_r <= prior[LEVELS];
      end
      // every qualifying update counts, no-change included
      if ((state_r == ST_APPLY) && found_r) count_r <= count_r + COUNT_W'(1);
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_price_r <= in_ch.level_price;
      req_qty_r   <= in_ch.level_quantity;
    end
    if (state_r == ST_SEL) slot_r <= slot_sel;
    if (emit_load) begin
      out_action_r <= op_r;
      out_slot_r   <= slot_r;
      out_price_r  <= cell_price[0];
      out_qty_r    <= cell_qty[0];
      out_count_r  <= count_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.action        = out_action_r;
  assign out_ch.slot          = out_slot_r;
  assign out_ch.best_price    = out_price_r;
  assign out_ch.best_quantity = out_qty_r;
  assign out_ch.update_count  = out_count_r;

  // checks
  `OBPLT_ASSERT_NEXT(a_accept_starts_compare, in_fire, state_r == ST_CMP)
  `OBPLT_ASSERT(a_first_hit_unique, (state_r != ST_APPLY) || $onehot0(first_q))
  `OBPLT_ASSERT(a_beyond_when_no_hit,
    (state_r != ST_APPLY) || ((op_r == ACT_BEYOND) == !found_r))
  `OBPLT_ASSERT_NEXT(a_count_steps_on_hit, (state_r == ST_APPLY) && found_r,
    count_r == $past(count_r) + COUNT_W'(1))

endmodule

// ----- dv/testbench.sv -----
module testbench;
  import obplt_pkg::*;

  // one result beat as the book should report it
  typedef struct packed {
    action_t            action;
    logic [SLOT_W-1:0]  slot;
    logic [PRICE_W-1:0] best_price;
    logic [QTY_W-1:0]   best_quantity;
    logic [COUNT_W-1:0] update_count;
  } book_result_t;

  // rows of the directed table: a level update or a register write
  typedef enum bit [1:0] {ROW_LEVEL, ROW_SIDE, ROW_FILL} drill_kind_t;

  typedef struct packed {
    drill_kind_t  kind;
    logic [31:0]  a;      // price, or register value
    logic [31:0]  b;      // quantity
    bit           typed;  // expected result written out in the row
    book_result_t res;
  } drill_row_t;

  localparam book_result_t NO_RES = '{ACT_NONE, '0, '0, '0, '0};
  localparam int HOLD_CYCLES    = 80;   // long output hold-off
  localparam int DRAIN_CYCLES   = 8;    // extra drain after the last result
  localparam int WATCHDOG_LIMIT = 2000; // cycles with no beat on any channel
  localparam int SHOW_LIMIT     = 100;  // mismatch lines printed before going quiet

  logic clk;
  logic rst_n;

  obplt_in_if  in_ch ();
  obplt_out_if out_ch ();
  obplt_cfg_if cfg_ch ();

  order_book_price_level_table_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow copy of the book side
  logic [PRICE_W-1:0] book_price [LEVELS];
  logic [QTY_W-1:0]   book_qty   [LEVELS];
  logic [COUNT_W-1:0] change_count;
  logic               bid_side;
  logic [FILL_W-1:0]  fill_mark;

  book_result_t pending_results [$];

  int mismatches;
  int beats_checked;
  int cfg_writes;
  int act_seen [5];
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  // directed table: expectations typed in where they are obvious
  drill_row_t drill_rows [22] = '{
    // asks, fill 0 after reset: nothing sorts at or after a real price
    '{ROW_LEVEL, 32'd5, 32'd10, 1'b1, '{ACT_BEYOND, 5'd0, 32'd0, 32'd0, 32'd1}},
    '{ROW_LEVEL, 32'd0, 32'd0, 1'b1, '{ACT_DELETE, 5'd0, 32'd0, 32'd0, 32'd2}},
    '{ROW_LEVEL, 32'd0, 32'd7, 1'b1, '{ACT_UPDATE, 5'd0, 32'd0, 32'd7, 32'd3}},
    // proper asks fill, counter bumps on refill
    '{ROW_FILL, 32'hFFFF_FFFF, 32'd0, 1'b0, NO_RES},
    '{ROW_LEVEL, 32'd100, 32'd5, 1'b1, '{ACT_INSERT, 5'd0, 32'd100, 32'd5, 32'd5}},
    '{ROW_LEVEL, 32'd50, 32'd1, 1'b1, '{ACT_INSERT, 5'd0, 32'd50, 32'd1, 32'd6}},
    '{ROW_LEVEL, 32'd100, 32'd9, 1'b1, '{ACT_UPDATE, 5'd1, 32'd50, 32'd1, 32'd7}},
    // zero quantity on an absent price still counts
    '{ROW_LEVEL, 32'd75, 32'd0, 1'b1, '{ACT_NONE, 5'd1, 32'd50, 32'd1, 32'd8}},
    // price equal to the fill value hits the first empty slot
    '{ROW_LEVEL, 32'hFFFF_FFFF, 32'd3, 1'b1,
      '{ACT_UPDATE, 5'd2, 32'd50, 32'd1, 32'd9}},
    '{ROW_LEVEL, 32'd0, 32'hFFFF_FFFF, 1'b1,
      '{ACT_INSERT, 5'd0, 32'd0, 32'hFFFF_FFFF, 32'd10}},
    '{ROW_LEVEL, 32'd0, 32'd0, 1'b1, '{ACT_DELETE, 5'd0, 32'd50, 32'd1, 32'd11}},
    '{ROW_LEVEL, 32'd50, 32'd0, 1'b1, '{ACT_DELETE, 5'd0, 32'd100, 32'd9, 32'd12}},
    // flip to bids without clearing: table now unsorted for this side
    '{ROW_SIDE, 32'd1, 32'd0, 1'b0, NO_RES},
    '{ROW_LEVEL, 32'd200, 32'd4, 1'b0, NO_RES},
    '{ROW_LEVEL, 32'd100, 32'd0, 1'b0, NO_RES},
    // bids with fill 0
    '{ROW_FILL, 32'd0, 32'd0, 1'b0, NO_RES},
    '{ROW_LEVEL, 32'hFFFF_FFFF, 32'd8, 1'b1,
      '{ACT_INSERT, 5'd0, 32'hFFFF_FFFF, 32'd8, 32'd16}},
    '{ROW_LEVEL, 32'd0, 32'd0, 1'b1,
      '{ACT_DELETE, 5'd1, 32'hFFFF_FFFF, 32'd8, 32'd17}},
    '{ROW_LEVEL, 32'hFFFF_FFFF, 32'd0, 1'b1, '{ACT_DELETE, 5'd0, 32'd0, 32'd0, 32'd18}},
    // bids with a fill that sorts first: only a price equal to the fill qualifies
    '{ROW_FILL, 32'hFFFF_FFFF, 32'd0, 1'b0, NO_RES},
    '{ROW_LEVEL, 32'd5, 32'd5, 1'b1,
      '{ACT_BEYOND, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd19}},
    '{ROW_LEVEL, 32'hFFFF_FFFF, 32'd0, 1'b1,
      '{ACT_DELETE, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd20}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // refill every slot with the fill mark, counts as a change
  function automatic void refill_book();
    for (int i = 0; i < LEVELS; i++) begin
      book_price[i] = fill_mark;
      book_qty[i]   = fill_mark;
    end
    change_count++;
  endfunction

  // apply one level update to the shadow book, return what the block should report
  function automatic book_result_t apply_level(logic [PRICE_W-1:0] price,
                                               logic [QTY_W-1:0] qty);
    book_result_t r;
    int hit;
    hit = -1;
    // first slot not ahead of the price, in index order
    for (int i = 0; i < LEVELS; i++) begin
      if (hit < 0 && (bid_side ? (book_price[i] <= price) : (book_price[i] >= price)))
        hit = i;
    end
    r.action = ACT_BEYOND;
    r.slot   = '0;
    if (hit >= 0) begin
      r.slot = hit[SLOT_W-1:0];
      if (book_price[hit] != price && qty != 0) begin
        // insert, last level falls off
        for (int i = LEVELS - 1; i > hit; i--) begin
          book_price[i] = book_price[i-1];
          book_qty[i]   = book_qty[i-1];
        end
        book_price[hit] = price;
        book_qty[hit]   = qty;
        r.action = ACT_INSERT;
      end else if (book_price[hit] == price && qty == 0) begin
        // delete, tail refilled
        for (int i = hit; i < LEVELS - 1; i++) begin
          book_price[i] = book_price[i+1];
          book_qty[i]   = book_qty[i+1];
        end
        book_price[LEVELS-1] = fill_mark;
        book_qty[LEVELS-1]   = fill_mark;
        r.action = ACT_DELETE;
      end else if (qty != 0) begin
        book_qty[hit] = qty;
        r.action = ACT_UPDATE;
      end else begin
        r.action = ACT_NONE;
      end
      change_count++;
    end
    r.best_price    = book_price[0];
    r.best_quantity = book_qty[0];
    r.update_count  = change_count;
    return r;
  endfunction

  function automatic void check_field(string tag, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
    end
  endfunction

  // offer one update, wait for its beat, record the expected result
  task automatic send_level(logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty,
                            bit typed, book_result_t typed_res);
    book_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.level_price    <= price;
    in_ch.level_quantity <= qty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_level(price, qty);
    if (typed) r = typed_res;
    act_seen[int'(r.action)]++;
    pending_results.push_back(r);
  endtask

  // stop offering, let every result come back and the pipeline empty out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    if (idx == CFG_SIDE_IS_BID) begin
      bid_side = value[0];
    end else begin
      fill_mark = value;
      refill_book();
    end
  endtask

  // one random phase: set the side (and maybe the fill), then stream updates
  task automatic run_phase(bit side, logic [31:0] fill, bit do_fill, int n_items,
                           int idle_pct, int stall_pct, bit pressure,
                           logic [31:0] base);
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    int pick;
    settle();
    write_reg(CFG_SIDE_IS_BID, {31'd0, side});
    if (do_fill) write_reg(CFG_EMPTY_MARK, fill);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      // long output hold-off while the sender keeps pushing
      if (pressure && (k % 30) == 0) hold_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 45) begin
        // hit a level that is in the book: delete, update or no-op
        price = book_price[$urandom_range(LEVELS - 1)];
        qty   = $urandom_range(1) ? 32'd0 : 32'($urandom);
      end else if (pick < 85) begin
        // narrow window so prices collide often
        price = base + $urandom_range(63);
        qty   = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(1000, 1));
      end else begin
        // full-range noise
        price = $urandom;
        qty   = $urandom_range(1) ? 32'($urandom) : 32'd0;
      end
      send_level(price, qty, 1'b0, NO_RES);
    end
  endtask

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker: oldest expectation against each accepted beat
  always @(posedge clk) begin
    book_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, got action %0d slot %0d",
                 $time, out_ch.action, out_ch.slot);
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        check_field("action", 32'(want.action), 32'(out_ch.action));
        check_field("slot", 32'(want.slot), 32'(out_ch.slot));
        check_field("best_price", want.best_price, out_ch.best_price);
        check_field("best_quantity", want.best_quantity, out_ch.best_quantity);
        check_field("update_count", want.update_count, out_ch.update_count);
      end
    end
  end

  // watchdog: any beat on any channel resets the count
  always @(posedge clk) begin
    int quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, quiet, pending_results.size());
      $display("order_book_price_level_table_unit regression: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.level_price    <= '0;
    in_ch.level_quantity <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_SIDE_IS_BID;
    cfg_ch.data          <= '0;
    rst_n                <= 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // reset state: asks, fill 0, counter 1 after the reset fill
    bid_side     = 1'b0;
    fill_mark    = '0;
    change_count = '0;
    refill_book();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (drill_rows[r]) begin
      case (drill_rows[r].kind)
        ROW_SIDE: begin
          settle();
          write_reg(CFG_SIDE_IS_BID, drill_rows[r].a);
        end
        ROW_FILL: begin
          settle();
          write_reg(CFG_EMPTY_MARK, drill_rows[r].a);
        end
        default: begin
          send_level(drill_rows[r].a, drill_rows[r].b, drill_rows[r].typed,
                     drill_rows[r].res);
        end
      endcase
    end

    // random phases, idle mixes cycle through none / sender / receiver / both
    run_phase(1'b0, 32'hFFFF_FFFF, 1'b1, 200, 0, 0, 1'b0, 32'd1000);
    run_phase(1'b1, 32'd0, 1'b1, 200, 53, 0, 1'b0, 32'd5000);
    run_phase(1'b0, {4'hF, 28'($urandom)}, 1'b1, 200, 0, 53, 1'b0,
              $urandom_range(32'h7FFF_FFFF));
    run_phase(1'b1, $urandom_range(255), 1'b1, 200, 36, 36, 1'b0,
              $urandom_range(32'hFFFF_0000, 256));
    // asks at the bottom of the price range, output held off repeatedly
    run_phase(1'b0, 32'hFFFF_FFFF, 1'b1, 150, 0, 0, 1'b1, 32'd0);
    // side flip with no refill: ascending book searched as bids
    run_phase(1'b1, 32'd0, 1'b0, 150, 36, 36, 1'b0, 32'd20);
    // fills that sort first: mostly beyond the table
    run_phase(1'b1, 32'hFFFF_FFFF, 1'b1, 100, 53, 0, 1'b0, 32'hFFFF_FFC0);
    run_phase(1'b0, 32'd0, 1'b1, 100, 0, 53, 1'b0, 32'd0);

    settle();

    $display("checked %0d result beats: %0d inserts, %0d deletes, %0d qty updates,",
             beats_checked, act_seen[0], act_seen[1], act_seen[2]);
    $display("  %0d no-ops, %0d beyond; %0d register writes, idle/stall mixes, hold-offs",
             act_seen[3], act_seen[4], cfg_writes);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("order_book_price_level_table_unit regression: pass");
    end else begin
      $display("order_book_price_level_table_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/obplt_pkg.sv
src/obplt_in_if.sv
src/obplt_out_if.sv
src/obplt_cfg_if.sv
src/obplt_cell.sv
src/order_book_price_level_table_unit.sv
dv/testbench.sv
